// ===== design/kalman_cv_tracker_3d_top_defines.svh =====
// Assertion macros of the Kalman tracker top module.
// Depends on nothing; included by files that assert.
`ifndef KALMAN_CV_TRACKER_3D_TOP_DEFINES_SVH
`define KALMAN_CV_TRACKER_3D_TOP_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define KCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Assert that a condition on one edge implies another on the next edge.
`define KCT_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);
`endif

// ===== design/kct_pkg.sv =====
// Types and constants of the Kalman tracker.
// Depends on nothing.
package kct_pkg;
	localparam int W = 48;
	typedef logic signed [W-1:0] q48_t;
	localparam q48_t MAX48 = {1'b0, {(W-1){1'b1}}};
	localparam q48_t MIN48 = {1'b1, {(W-1){1'b0}}};
	localparam logic [1:0] CFG_Q = 2'd0;
	localparam logic [1:0] CFG_R = 2'd1;
	localparam logic [1:0] CFG_P0 = 2'd2;

	function automatic q48_t sat48(input logic signed [W:0] v);
		if (v > $signed({2'b00, {(W-1){1'b1}}})) return MAX48;
		if (v < $signed({2'b11, {(W-1){1'b0}}})) return MIN48;
		return v[W-1:0];
	endfunction
endpackage

// ===== design/kct_if.sv =====
// Valid/ready channel interfaces of the tracker.
// Depends on nothing.
interface kct_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [19:0] time_step;
	modport source (output valid, pos_x, pos_y, pos_z, time_step, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, time_step, output ready);
endinterface

interface kct_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic signed [31:0] est_z;
	modport source (output valid, est_x, est_y, est_z, input ready);
	modport sink (input valid, est_x, est_y, est_z, output ready);
endinterface

interface kct_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/kct_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
module kct_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== design/kct_mul.sv =====
// Signed Q48 multiplier with rounding and saturation.
// Depends on kct_pkg.
module kct_mul import kct_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  q48_t a,
	input  q48_t b,
	output logic done,
	output q48_t p
);
	logic [2:0] vld_q;
	logic neg_s1, neg_s2;
	logic [47:0] ma_s1, mb_s1;
	logic [47:0] ll_s2, lh_s2, hl_s2, hh_s2;
	logic [95:0] full;
	logic [95:0] rnd;
	logic [47:0] cap, mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[1:0], start};
	end

	always_ff @(posedge clk) begin
		neg_s1 <= a[47] ^ b[47];
		ma_s1 <= a[47] ? 48'(-a) : 48'(a);
		mb_s1 <= b[47] ? 48'(-b) : 48'(b);
		neg_s2 <= neg_s1;
		ll_s2 <= 48'(ma_s1[23:0] * mb_s1[23:0]);
		lh_s2 <= 48'(ma_s1[23:0] * mb_s1[47:24]);
		hl_s2 <= 48'(ma_s1[47:24] * mb_s1[23:0]);
		hh_s2 <= 48'(ma_s1[47:24] * mb_s1[47:24]);
	end

	always_comb begin
		full = {48'd0, ll_s2} + ({48'd0, lh_s2} << 24) + ({48'd0, hl_s2} << 24)
			+ ({48'd0, hh_s2} << 48);
		rnd = (full + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		cap = neg_s2 ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		mag = (rnd[95:48] != '0 || rnd[47:0] > cap) ? cap : rnd[47:0];
	end

	always_ff @(posedge clk) begin
		p <= neg_s2 ? q48_t'(-mag) : q48_t'(mag);
	end
	assign done = vld_q[2];
endmodule

// ===== design/kct_div.sv =====
// Restoring bit-serial Q48 divider, one quotient bit a cycle.
// Depends on kct_pkg.
module kct_div import kct_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  q48_t n,
	input  q48_t d,
	output logic done,
	output q48_t q
);
	localparam int STEPS = 48 + FRAC_BITS;
	logic busy_q, neg_q, sat_q, zero_q;
	logic [$clog2(STEPS+1)-1:0] cnt_q;
	logic [STEPS-1:0] num_q;
	logic [48:0] rem_q, rem_sh;
	logic [47:0] den_q, quo_q, cap;
	logic qb;
	logic [48:0] qn;

	assign cap = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
	assign rem_sh = {rem_q[47:0], num_q[STEPS-1]};
	assign qb = rem_sh >= {1'b0, den_q};
	assign qn = {quo_q, qb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= ($clog2(STEPS+1))'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= n[47];
			zero_q <= d[47] || d == '0;
			num_q <= {(n[47] ? 48'(-n) : 48'(n)), {FRAC_BITS{1'b0}}};
			den_q <= d;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= qb ? rem_sh - {1'b0, den_q} : rem_sh;
			if (!sat_q) begin
				if (qn > {1'b0, cap}) begin
					quo_q <= cap;
					sat_q <= 1'b1;
				end else quo_q <= qn[47:0];
			end
		end
	end

	assign q = zero_q ? '0 : (neg_q ? q48_t'(-quo_q) : q48_t'(quo_q));
endmodule

// ===== design/kalman_cv_tracker_3d_top.sv =====
// Three-axis constant-velocity Kalman tracker, Q16.16 ports, Q32.16 inside.
// The first item only writes the initial state of every axis; each later item has every
// axis read its state, run nine multiplies and two divides, and write the state back.
// Throughput: one transaction in flight; the next can be taken in the cycle after the
// estimate leaves.
// Reset clears the primed flag and loads the register reset values; the state
// memory needs no clearing since the first item writes every entry it reads.
`include "kalman_cv_tracker_3d_top_defines.svh"
module kalman_cv_tracker_3d_top import kct_pkg::*; #(
	parameter int AXES = 3,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	kct_in_if.sink in_ch,
	kct_out_if.source out_ch,
	kct_cfg_if.sink cfg
);
	// Per axis memory layout: p, v, P00, P01, P11 at base 8*axis.
	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_RD   = 12'b000000000010,
		ST_LD   = 12'b000000000100,
		ST_M1   = 12'b000000001000,
		ST_M2   = 12'b000000010000,
		ST_M3   = 12'b000000100000,
		ST_DIV0 = 12'b000001000000,
		ST_DIV1 = 12'b000010000000,
		ST_M4   = 12'b000100000000,
		ST_M5   = 12'b001000000000,
		ST_WR   = 12'b010000000000,
		ST_OUT  = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [31:0] q_noise_q, r_noise_q, p0_q;
	logic primed_q;
	logic [1:0] axis_q;
	logic [2:0] sub_q;
	logic [19:0] dt_q;
	logic signed [31:0] meas_q [3];
	logic signed [31:0] est_q [3];
	q48_t p_q, v_q, c00_q, c01_q, c11_q;
	q48_t pp_q, p00n_q, p01n_q, p11n_q, k0_q, k1_q, e_q;
	logic [4:0] ram_addr;
	logic ram_we;
	q48_t ram_wdata, ram_rdata;
	logic mul_start, mul_done, div_start, div_done;
	q48_t mul_a, mul_b, mul_p, div_n, div_d, div_q;
	q48_t dt48, meas48;
	logic [2:0] step_q;
	logic in_acc;

	assign dt48 = q48_t'({28'd0, dt_q});
	assign meas48 = q48_t'(meas_q[axis_q]);
	assign cfg.ready = 1'b1;
	// Hold the input while an estimate still waits to leave.
	assign in_ch.ready = state_q == ST_IDLE && !out_ch.valid;
	assign in_acc = in_ch.valid && in_ch.ready;

	kct_ram #(.WIDTH(48), .DEPTH(32)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);
	kct_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);
	kct_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.done(div_done), .q(div_q)
	);

	// Hold configuration writes; drop unknown indexes, and P0 writes once primed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= 32'd6553600;
			r_noise_q <= 32'd6553600;
			p0_q <= 32'd13107200;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_Q: q_noise_q <= cfg.data;
				CFG_R: r_noise_q <= cfg.data;
				CFG_P0: if (!primed_q) p0_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Memory address and write data follow the sequencer's sub-step.
	always_comb begin
		ram_addr = {axis_q, sub_q};
		ram_we = 1'b0;
		ram_wdata = '0;
		if (state_q == ST_WR) begin
			ram_we = 1'b1;
			unique case (sub_q)
				3'd0: ram_wdata = primed_q ? pp_q : meas48;
				3'd1: ram_wdata = primed_q ? v_q : '0;
				3'd2: ram_wdata = primed_q ? c00_q : q48_t'({16'd0, p0_q});
				3'd3: ram_wdata = primed_q ? c01_q : '0;
				default: ram_wdata = primed_q ? c11_q : q48_t'({16'd0, p0_q});
			endcase
		end
	end

	// Multiplier operands by state and step: M1 dt*v, dt*P11; M2 dt*P01, dt*P01n;
	// M4 K0*e, K1*e; M5 K0*P00n, K0*P01n, K1*P01n.
	always_comb begin
		mul_a = dt48;
		mul_b = v_q;
		unique case (state_q)
			ST_M1: begin mul_a = dt48; mul_b = step_q == 3'd0 ? v_q : c11_q; end
			ST_M2: begin mul_a = dt48; mul_b = step_q == 3'd0 ? c01_q : p01n_q; end
			ST_M4: begin
				mul_a = step_q == 3'd0 ? k0_q : k1_q;
				mul_b = e_q;
			end
			ST_M5: begin
				mul_a = step_q == 3'd2 ? k1_q : k0_q;
				mul_b = step_q == 3'd0 ? p00n_q : p01n_q;
			end
			default: ;
		endcase
	end
	// Innovation variance from the predicted P00 plus R; P00 stays stable through both divides.
	assign div_n = state_q == ST_DIV0 ? p00n_q : p01n_q;
	assign div_d = sat48({p00n_q[47], p00n_q} + 49'({17'd0, r_noise_q}));

	logic mul_pend_q, div_pend_q;
	assign mul_start = !mul_pend_q && (state_q == ST_M1 || state_q == ST_M2
		|| state_q == ST_M4 || state_q == ST_M5);
	assign div_start = !div_pend_q && (state_q == ST_DIV0 || state_q == ST_DIV1);

	function automatic logic signed [31:0] out32(input q48_t v);
		if (v > 48'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -48'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			primed_q <= 1'b0;
			out_ch.valid <= 1'b0;
			mul_pend_q <= 1'b0;
			div_pend_q <= 1'b0;
			axis_q <= '0;
			sub_q <= '0;
			step_q <= '0;
		end else begin
			if (state_q == ST_OUT) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					axis_q <= '0;
					sub_q <= '0;
					for (int i = 0; i < 3; i++) if (i >= AXES) est_q[i] <= '0;
					state_q <= primed_q ? ST_RD : ST_WR;
				end
				ST_RD: state_q <= ST_LD;
				ST_LD: begin
					// Registered read data lands in the cycle after the address.
					unique case (sub_q)
						3'd0: p_q <= ram_rdata;
						3'd1: v_q <= ram_rdata;
						3'd2: c00_q <= ram_rdata;
						3'd3: c01_q <= ram_rdata;
						default: c11_q <= ram_rdata;
					endcase
					if (sub_q == 3'd4) begin
						sub_q <= '0;
						step_q <= '0;
						state_q <= ST_M1;
					end else begin
						sub_q <= sub_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_M1: begin
					mul_pend_q <= !mul_done;
					if (mul_done) begin
						if (step_q == 3'd0) begin
							pp_q <= sat48({p_q[47], p_q} + {mul_p[47], mul_p});
							step_q <= 3'd1;
						end else begin
							p01n_q <= sat48({c01_q[47], c01_q} + {mul_p[47], mul_p});
							step_q <= '0;
							state_q <= ST_M2;
						end
					end
				end
				ST_M2: begin
					mul_pend_q <= !mul_done;
					if (mul_done) begin
						if (step_q == 3'd0) begin
							p00n_q <= sat48({c00_q[47], c00_q} + {mul_p[47], mul_p});
							step_q <= 3'd1;
						end else begin
							p00n_q <= sat48({p00n_q[47], p00n_q} + {mul_p[47], mul_p});
							state_q <= ST_M3;
						end
					end
				end
				ST_M3: begin
					// Add process noise and form the innovation.
					p00n_q <= sat48({p00n_q[47], p00n_q} + 49'({17'd0, q_noise_q}));
					p11n_q <= sat48({c11_q[47], c11_q} + 49'({17'd0, q_noise_q}));
					e_q <= sat48({meas48[47], meas48} - {pp_q[47], pp_q});
					state_q <= ST_DIV0;
				end
				ST_DIV0, ST_DIV1: begin
					div_pend_q <= !div_done;
					if (div_done) begin
						if (state_q == ST_DIV0) begin
							k0_q <= div_q;
							state_q <= ST_DIV1;
						end else begin
							k1_q <= div_q;
							step_q <= '0;
							state_q <= ST_M4;
						end
					end
				end
				ST_M4: begin
					mul_pend_q <= !mul_done;
					if (mul_done) begin
						if (step_q == 3'd0) begin
							pp_q <= sat48({pp_q[47], pp_q} + {mul_p[47], mul_p});
							step_q <= 3'd1;
						end else begin
							v_q <= sat48({v_q[47], v_q} + {mul_p[47], mul_p});
							step_q <= '0;
							state_q <= ST_M5;
						end
					end
				end
				ST_M5: begin
					mul_pend_q <= !mul_done;
					if (mul_done) begin
						unique case (step_q)
							3'd0: c00_q <= sat48({p00n_q[47], p00n_q} - {mul_p[47], mul_p});
							3'd1: c01_q <= sat48({p01n_q[47], p01n_q} - {mul_p[47], mul_p});
							default: c11_q <= sat48({p11n_q[47], p11n_q} - {mul_p[47], mul_p});
						endcase
						if (step_q == 3'd2) begin
							sub_q <= '0;
							state_q <= ST_WR;
						end else step_q <= step_q + 1'b1;
					end
				end
				ST_WR: begin
					if (sub_q == 3'd0)
						est_q[axis_q] <= primed_q ? out32(pp_q) : meas_q[axis_q];
					if (sub_q == 3'd4) begin
						sub_q <= '0;
						if (32'(axis_q) == AXES - 1) state_q <= ST_OUT;
						else begin
							axis_q <= axis_q + 1'b1;
							state_q <= primed_q ? ST_RD : ST_WR;
						end
					end else sub_q <= sub_q + 1'b1;
				end
				ST_OUT: begin
					primed_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dt_q <= in_ch.time_step;
			meas_q[0] <= in_ch.pos_x;
			meas_q[1] <= in_ch.pos_y;
			meas_q[2] <= in_ch.pos_z;
		end
	end

	assign out_ch.est_x = est_q[0];
	assign out_ch.est_y = est_q[1];
	assign out_ch.est_z = est_q[2];

	`KCT_ASSERT(a_no_dual_unit, !(mul_pend_q && div_pend_q), "mul and div overlap")
	`KCT_ASSERT_NEXT(a_accept_leaves_idle, in_ch.valid && in_ch.ready,
		state_q != ST_IDLE, "accepted transaction left block idle")
	`KCT_ASSERT(a_wr_only_in_wr, !ram_we || state_q == ST_WR, "stray state write")
endmodule

// ===== tb/sv/kct_tb_if.sv =====
// Holds no code of its own; the tracker testbench top uses the channel interfaces
// of design/kct_if.sv, which holds the interfaces the block's ports expect.

// ===== tb/sv/kalman_cv_tracker_3d_top_test.sv =====
// Self-checking testbench of the three-axis Kalman tracker.
// Depends on kct_pkg, the channel interfaces and kalman_cv_tracker_3d_top.
module kalman_cv_tracker_3d_top_test import kct_pkg::*;;

	typedef logic signed [47:0] fx_t;
	localparam fx_t FX_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam fx_t FX_MIN = 48'sh8000_0000_0000;
	localparam int FRAC = 16;

	// Tracker predictor plus a queue of predicted estimates
	class track_board;
		bit primed;
		fx_t pos[3];
		fx_t vel[3];
		fx_t c00[3], c01[3], c11[3];
		logic [31:0] q_noise, r_noise, p_init;
		logic [95:0] est_q[$];
		int errors;
		int checked;

		function new();
			primed = 0;
			q_noise = 32'd6553600;
			r_noise = 32'd6553600;
			p_init = 32'd13107200;
			errors = 0;
			checked = 0;
			foreach (pos[i]) begin
				pos[i] = 0; vel[i] = 0; c00[i] = 0; c01[i] = 0; c11[i] = 0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				CFG_Q: q_noise = val;
				CFG_R: r_noise = val;
				CFG_P0: p_init = val;
				default: ;
			endcase
		endfunction

		function fx_t clip(logic signed [49:0] v);
			if (v > 50'sd140737488355327) return FX_MAX;
			if (v < -50'sd140737488355328) return FX_MIN;
			return v[47:0];
		endfunction

		function fx_t plus(fx_t a, fx_t b);
			return clip(50'(a) + 50'(b));
		endfunction

		function fx_t minus(fx_t a, fx_t b);
			return clip(50'(a) - 50'(b));
		endfunction

		// Rounded half away from zero, saturated on the magnitude
		function fx_t fmul(fx_t a, fx_t b);
			logic [47:0] ma, mb;
			logic [96:0] prod;
			logic [80:0] m;
			logic [48:0] cap;
			bit neg;
			neg = (a < 0) != (b < 0);
			ma = (a < 0) ? -a : a;
			mb = (b < 0) ? -b : b;
			prod = 97'(ma) * 97'(mb) + (97'd1 << (FRAC - 1));
			m = prod >> FRAC;
			cap = neg ? 49'h8000_0000_0000 : 49'h7FFF_FFFF_FFFF;
			if (m > 81'(cap)) m = 81'(cap);
			return neg ? fx_t'(-m[48:0]) : fx_t'(m[47:0]);
		endfunction

		// Quotient truncated toward zero, zero for a non-positive divisor
		function fx_t fdiv(fx_t n, fx_t d);
			logic [47:0] mn;
			logic [111:0] num, quo;
			logic [48:0] cap;
			bit neg;
			if (d <= 0) return 0;
			neg = n < 0;
			mn = neg ? -n : n;
			num = 112'(mn) << FRAC;
			quo = num / 112'(d);
			cap = neg ? 49'h8000_0000_0000 : 49'h7FFF_FFFF_FFFF;
			if (quo > 112'(cap)) quo = 112'(cap);
			return neg ? fx_t'(-quo[48:0]) : fx_t'(quo[47:0]);
		endfunction

		function logic [31:0] narrow(fx_t v);
			if (v > 48'sh0000_7FFF_FFFF) return 32'h7FFF_FFFF;
			if (v < -48'sh0000_8000_0000) return 32'h8000_0000;
			return v[31:0];
		endfunction

		function void note_measurement(logic [31:0] meas[3], logic [19:0] dt_raw);
			fx_t dt, q, r, m, pp, p01n, p00n, p11n, s, k0, k1, e;
			logic [95:0] est;
			dt = fx_t'(dt_raw);
			q = fx_t'(q_noise);
			r = fx_t'(r_noise);
			for (int a = 0; a < 3; a++) begin
				m = fx_t'($signed(meas[a]));
				if (!primed) begin
					pos[a] = m; vel[a] = 0;
					c00[a] = fx_t'(p_init); c01[a] = 0; c11[a] = fx_t'(p_init);
					est[32*a +: 32] = meas[a];
					continue;
				end
				pp = plus(pos[a], fmul(dt, vel[a]));
				p01n = plus(c01[a], fmul(dt, c11[a]));
				p00n = plus(plus(plus(c00[a], fmul(dt, c01[a])), fmul(dt, p01n)), q);
				p11n = plus(c11[a], q);
				s = plus(p00n, r);
				k0 = fdiv(p00n, s);
				k1 = fdiv(p01n, s);
				e = minus(m, pp);
				pos[a] = plus(pp, fmul(k0, e));
				vel[a] = plus(vel[a], fmul(k1, e));
				c00[a] = minus(p00n, fmul(k0, p00n));
				c01[a] = minus(p01n, fmul(k0, p01n));
				c11[a] = minus(p11n, fmul(k1, p01n));
				est[32*a +: 32] = narrow(pos[a]);
			end
			primed = 1;
			est_q.push_back(est);
		endfunction

		function void check_estimate(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
			logic [95:0] want;
			checked++;
			if (est_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected estimate %h %h %h", ex, ey, ez);
				return;
			end
			want = est_q.pop_front();
			if (want != {ez, ey, ex}) begin
				errors++;
				if (errors <= 10)
					$display("estimate %0d mismatch: exp x=%h y=%h z=%h got x=%h y=%h z=%h",
						checked, want[31:0], want[63:32], want[95:64], ex, ey, ez);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	kct_in_if in_ch();
	kct_out_if out_ch();
	kct_cfg_if cfg();

	kalman_cv_tracker_3d_top u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	track_board board = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int cfg_writes = 0;
	localparam int WATCHDOG = 20000;

	// Receiver: stall at random and check each estimate transaction on acceptance
	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else begin
			if (out_ch.valid && out_ch.ready)
				board.check_estimate(out_ch.est_x, out_ch.est_y, out_ch.est_z);
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles in which no transaction of any kind moves
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Idle at random with valid low, then hold one measurement until the block takes it
	task automatic send_measurement(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [19:0] dt);
		logic [31:0] meas[3];
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.pos_x <= x; in_ch.pos_y <= y; in_ch.pos_z <= z;
		in_ch.time_step <= dt;
		do @(posedge clk); while (!in_ch.ready);
		meas[0] = x; meas[1] = y; meas[2] = z;
		board.note_measurement(meas, dt);
		items_sent++;
	endtask

	// Drop valid, wait out every pending estimate, then some slack for the block
	task automatic drain();
		in_ch.valid <= 0;
		while (board.est_q.size() != 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, val);
		cfg_writes++;
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// Mostly a moving target with noise; now and then anything at all
	task automatic random_measurement(ref logic signed [31:0] tx, ty, tz);
		logic [19:0] dt;
		int kind;
		kind = $urandom_range(9);
		dt = (kind < 7) ? 20'($urandom_range(32768, 0)) : 20'($urandom);
		if (kind < 8) begin
			tx += $signed(32'($urandom_range(40000))) - 20000;
			ty += $signed(32'($urandom_range(40000))) - 20000;
			tz += $signed(32'($urandom_range(40000))) - 20000;
			send_measurement(tx, ty, tz, dt);
		end else
			send_measurement($urandom, $urandom, $urandom, dt);
	endtask

	initial begin
		logic signed [31:0] tx, ty, tz;
		in_ch.valid = 0; in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
		in_ch.time_step = 0;
		cfg.valid = 0; cfg.index = CFG_Q; cfg.data = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: first item is echoed and ignores its time step
		send_measurement(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 20'hFFFFF);
		send_measurement(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 20'h0);
		send_measurement(32'h0, 32'h0, 32'hFFFF_FFFF, 20'hFFFFF);
		send_measurement(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 20'h10000);
		send_measurement(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 20'h80000);
		drain();

		// Noise registers at their extremes; zero noise leaves the variance at the predicted P00
		write_reg(CFG_Q, 32'h0);
		write_reg(CFG_R, 32'h0);
		write_reg(CFG_P0, 32'h0);
		send_measurement(32'h0, 32'h0, 32'h0, 20'h10000);
		send_measurement(32'h0005_0000, 32'hFFFB_0000, 32'h0, 20'h10000);
		drain();
		write_reg(CFG_Q, 32'hFFFF_FFFF);
		write_reg(CFG_R, 32'hFFFF_FFFF);
		write_reg(CFG_P0, 32'hFFFF_FFFF);
		send_measurement(32'h1234_5678, 32'h8765_4321, 32'h5555_AAAA, 20'hFFFFF);
		send_measurement(32'hAAAA_5555, 32'h0, 32'h7FFF_FFFF, 20'hFFFFF);
		send_measurement(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h00001);
		drain();
		write_reg(CFG_Q, 32'h0000_0100);
		write_reg(CFG_R, 32'h0064_0000);
		send_measurement(32'h0, 32'h0, 32'h0, 20'h0);
		send_measurement(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 20'h08000);
		drain();

		// Random phases with three idling patterns and register writes in each
		tx = 0; ty = 0; tz = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 78 : 0;
			recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 11 : 0;
			write_reg(CFG_Q, $urandom_range(32'h0100_0000));
			write_reg(CFG_R, (ph == 2) ? $urandom : $urandom_range(32'h0100_0000));
			write_reg(CFG_P0, $urandom);
			for (int n = 0; n < 410; n++) begin
				random_measurement(tx, ty, tz);
				if (n == 200) drain();
			end
			drain();
		end

		$display("%0d measurements and %0d register writes, %0d estimates checked",
			items_sent, cfg_writes, board.checked);
		$display("idling patterns: sender-light, receiver-light and back-to-back");
		if (board.errors == 0 && board.est_q.size() == 0)
			$display("Regression PASS");
		else begin
			$display("%0d mismatches, %0d estimates outstanding", board.errors,
				board.est_q.size());
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
